// ===== sv/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
// Included by the top level; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m");
`define RAU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m");
`else
`define RAU_ASSERT(label, prop)
`define RAU_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== sv/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  localparam int unsigned OpW  = 16;
  localparam int unsigned DenW = OpW - 1;
  localparam int unsigned ResW = 32;
  localparam int unsigned MagW = 2 * OpW + 2;
  localparam int unsigned CntW = $clog2(MagW + 1);

  localparam logic [3:0] ModeAdd = 4'd0;
  localparam logic [3:0] ModeSub = 4'd1;
  localparam logic [3:0] ModeMul = 4'd2;
  localparam logic [3:0] ModeDiv = 4'd3;
  localparam logic [3:0] ModeNeg = 4'd4;
  localparam logic [3:0] ModeInc = 4'd5;
  localparam logic [3:0] ModeDec = 4'd6;
  localparam logic [3:0] ModeLt  = 4'd7;
  localparam logic [3:0] ModeLe  = 4'd8;
  localparam logic [3:0] ModeGt  = 4'd9;
  localparam logic [3:0] ModeGe  = 4'd10;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands
    logic prod;     // register cross products
    logic form;     // form n/d and classify
    logic div_go;   // start a remainder step sequence
    logic div_step; // one restoring division bit
    logic swap;     // euclid x<-y, y<-rem
    logic qstart;   // start dividing n and d by gcd
    logic qsel;     // 0: divide n, 1: divide d
    logic qsave;    // store quotient
    logic out;      // build result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reduce;   // mode needs gcd reduction
    logic y_zero;
    logic div_last;
  } sts_t;
endpackage

// ===== sv/rau_datapath.sv =====
// Datapath: cross products, Euclidean gcd with a bit-serial divider, result.
// Depends on rau_pkg.
module rau_datapath (
  input  logic                     clk_i,
  input  logic [3:0]               mode_i,
  input  logic [rau_pkg::OpW-1:0]  a_num_i,
  input  logic [rau_pkg::DenW-1:0] a_den_i,
  input  logic [rau_pkg::OpW-1:0]  b_num_i,
  input  logic [rau_pkg::DenW-1:0] b_den_i,
  input  rau_pkg::cmd_t            cmd_i,
  output rau_pkg::sts_t            sts_o,
  output logic [rau_pkg::ResW-1:0] res_num_o,
  output logic [rau_pkg::ResW-2:0] res_den_o,
  output logic                     cmp_true_o,
  output logic                     div_error_o
);
  import rau_pkg::*;

  localparam int unsigned PW = 2 * OpW;

  logic [3:0] mode_q;
  logic signed [OpW-1:0] an_q, bn_q;
  logic [DenW-1:0] ad_q, bd_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic neg_q, err_q, red_q;
  logic [MagW-1:0] x_q, y_q, un_q, ud_q;
  logic [MagW-1:0] dvd_q, dvs_q, quo_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic [MagW-1:0] rem_sh, rem_sub;

  logic signed [MagW-1:0] n_d, d_d;
  always_comb begin
    n_d = '0;
    d_d = '0;
    case (mode_q)
      ModeAdd: begin n_d = MagW'(p1_q) + MagW'(p2_q); d_d = MagW'(p3_q); end
      ModeSub: begin n_d = MagW'(p1_q) - MagW'(p2_q); d_d = MagW'(p3_q); end
      ModeMul: begin n_d = MagW'(p4_q); d_d = MagW'(p3_q); end
      ModeDiv: begin n_d = MagW'(p1_q); d_d = MagW'(p2_q); end
      ModeNeg: begin n_d = -MagW'(an_q); d_d = MagW'({1'b0, ad_q}); end
      default: ;
    endcase
  end

  assign rem_sh  = {rem_q[MagW-2:0], dvd_q[MagW-1]};
  assign rem_sub = rem_sh - dvs_q;

  // operand, product, euclid and quotient registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i; an_q <= a_num_i; ad_q <= a_den_i;
      bn_q <= b_num_i; bd_q <= b_den_i;
    end
    if (cmd_i.prod) begin
      p1_q <= PW'(an_q) * PW'($signed({1'b0, bd_q}));
      p2_q <= PW'(bn_q) * PW'($signed({1'b0, ad_q}));
      p3_q <= PW'($signed({1'b0, ad_q})) * PW'($signed({1'b0, bd_q}));
      p4_q <= PW'(an_q) * PW'(bn_q);
    end
    if (cmd_i.form) begin
      neg_q <= n_d[MagW-1] ^ d_d[MagW-1];
      err_q <= (d_d == '0);
      red_q <= (mode_q <= ModeNeg) && (d_d != '0);
      un_q  <= n_d[MagW-1] ? -n_d : n_d;
      ud_q  <= d_d[MagW-1] ? -d_d : d_d;
      x_q   <= n_d[MagW-1] ? -n_d : n_d;
      y_q   <= d_d[MagW-1] ? -d_d : d_d;
    end
    if (cmd_i.div_go) begin
      dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; quo_q <= '0;
      cnt_q <= CntW'(MagW - 1);
    end else if (cmd_i.qstart) begin
      dvd_q <= cmd_i.qsel ? ud_q : un_q; dvs_q <= x_q;
      rem_q <= '0; quo_q <= '0; cnt_q <= CntW'(MagW - 1);
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[MagW-2:0], 1'b0};
      if (rem_sh >= dvs_q) begin
        rem_q <= rem_sub; quo_q <= {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh; quo_q <= {quo_q[MagW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.swap) begin
      x_q <= y_q; y_q <= rem_q;
    end
    // a save that also starts the next division is the numerator's
    if (cmd_i.qsave) begin
      if (cmd_i.qsel && !cmd_i.qstart) ud_q <= quo_q;
      else un_q <= quo_q;
    end
  end

  assign sts_o.reduce   = red_q;
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_last = (cnt_q == '0);

  // result assembly
  logic [ResW-1:0] rn_d;
  logic [ResW-2:0] rd_d;
  logic cmp_d, err_d;
  logic signed [MagW-1:0] id_sum;
  always_comb begin
    rn_d = '0; rd_d = '0; cmp_d = 1'b0; err_d = 1'b0;
    id_sum = (mode_q == ModeInc) ? MagW'(an_q) + MagW'({1'b0, ad_q})
                                 : MagW'(an_q) - MagW'({1'b0, ad_q});
    case (mode_q)
      ModeAdd, ModeSub, ModeMul, ModeDiv, ModeNeg: begin
        if (err_q) begin
          rd_d = (ResW-1)'(1); err_d = 1'b1;
        end else begin
          rn_d = neg_q ? ResW'(-un_q) : ResW'(un_q);
          rd_d = (ResW-1)'(ud_q);
        end
      end
      ModeInc, ModeDec: begin
        if (ad_q == '0) begin
          rd_d = (ResW-1)'(1); err_d = 1'b1;
        end else begin
          rn_d = ResW'(id_sum);
          rd_d = (ResW-1)'(ad_q);
        end
      end
      ModeLt: cmp_d = p1_q <  p2_q;
      ModeLe: cmp_d = p1_q <= p2_q;
      ModeGt: cmp_d = p1_q >  p2_q;
      ModeGe: cmp_d = p1_q >= p2_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      res_num_o <= rn_d; res_den_o <= rd_d;
      cmp_true_o <= cmp_d; div_error_o <= err_d;
    end
  end
endmodule

// ===== sv/rau_ctrl.sv =====
// Controller state machine sequencing the datapath and the stream handshake.
// Depends on rau_pkg.
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o
);
  import rau_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StProd  = 9'b000000010,
    StForm  = 9'b000000100,
    StTest  = 9'b000001000,
    StGstep = 9'b000010000,
    StSwap  = 9'b000100000,
    StQstep = 9'b001000000,
    StQsave = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic qsel_q, qsel_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    qsel_d  = qsel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.qsel = qsel_q;
    case (state_q)
      StIdle: if (in_fire_i) begin cmd_o.load = 1'b1; state_d = StProd; end
      StProd: begin cmd_o.prod = 1'b1; state_d = StForm; end
      StForm: begin cmd_o.form = 1'b1; state_d = StTest; end
      StTest: begin
        if (!sts_i.reduce) state_d = StOut;
        else if (sts_i.y_zero) begin
          cmd_o.qstart = 1'b1; cmd_o.qsel = 1'b0; qsel_d = 1'b0; state_d = StQstep;
        end else begin
          cmd_o.div_go = 1'b1; state_d = StGstep;
        end
      end
      StGstep: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StSwap;
      end
      StSwap: begin cmd_o.swap = 1'b1; state_d = StTest; end
      StQstep: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StQsave;
      end
      StQsave: begin
        cmd_o.qsave = 1'b1;
        if (qsel_q) state_d = StOut;
        else begin
          cmd_o.qstart = 1'b1; cmd_o.qsel = 1'b1; qsel_d = 1'b1; state_d = StQstep;
        end
      end
      // load the output register once the previous beat has gone
      StOut: if (!out_valid_q || out_ready_i) begin
        cmd_o.out = 1'b1; out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // qsave uses the current selector; the next quotient start sets it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; qsel_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; qsel_q <= qsel_d; out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one fraction result per input beat, one beat worked
// at a time; an output register lets the next beat be taken while a result waits.
// Inc, dec, compares, unused modes and errors skip reduction and go straight to the
// output. Add, sub, mul, div and neg reduce by a Euclidean gcd on a 34-bit
// bit-serial divider: one division per remainder step, then two divisions of n
// and d by the gcd. A new beat is taken from the cycle after the result is
// loaded; a stalled output holds the unit before that load. Depends on rau_pkg,
// rau_ctrl, rau_datapath and the assertion header.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[3:0], a_num[19:4], a_den[34:20], b_num[50:35], b_den[65:51], pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_num[31:0], res_den[62:32], cmp_true[63], div_error[64], pad
  output logic [71:0] m_axis_tdata
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;
  logic [ResW-1:0] res_num;
  logic [ResW-2:0] res_den;
  logic cmp_true, div_error;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  rau_datapath u_dp (
    .clk_i,
    .mode_i(s_axis_tdata[3:0]), .a_num_i(s_axis_tdata[19:4]),
    .a_den_i(s_axis_tdata[34:20]), .b_num_i(s_axis_tdata[50:35]),
    .b_den_i(s_axis_tdata[65:51]),
    .cmd_i(cmd), .sts_o(sts),
    .res_num_o(res_num), .res_den_o(res_den),
    .cmp_true_o(cmp_true), .div_error_o(div_error)
  );

  assign m_axis_tdata = {7'd0, div_error, cmp_true, res_den, res_num};

  `RAU_ASSERT(a_valid_known, !$isunknown(m_axis_tvalid))
  `RAU_ASSERT_NEXT(a_accept_busy, in_fire, !s_axis_tready)
  `RAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ===== test/tb_top.sv =====
// Testbench for the rational arithmetic unit: directed and random fraction beats,
// predicted in a local model and checked field by field. Depends on rau_pkg and the RTL.
module tb_top;
  import rau_pkg::*;

  typedef struct packed {
    logic        err;
    logic        cmp;
    logic [30:0] den;
    logic [31:0] num;
  } frac_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  frac_res_t   expected_q[$];
  int          n_errors = 0;
  int          idle_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_rx = 1'b0;

  rational_arithmetic_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Integer gcd on magnitudes
  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    return x;
  endfunction

  // Reduce n/d, sign on numerator; zero d flags an error
  function automatic frac_res_t reduce_frac(longint n, longint d);
    frac_res_t r;
    longint unsigned un, ud, g;
    bit neg;
    r = '0;
    if (d == 0) begin
      r.den = 31'd1;
      r.err = 1'b1;
      return r;
    end
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    g = gcd64(un, ud);
    if (g == 0) g = 1;
    un = un / g;
    ud = ud / g;
    r.num = 32'(neg ? -un : un);
    r.den = 31'(ud);
    return r;
  endfunction

  function automatic frac_res_t predict_frac(logic [3:0] mode, logic signed [15:0] an_i,
                                             logic [14:0] ad_i, logic signed [15:0] bn_i,
                                             logic [14:0] bd_i);
    frac_res_t r;
    longint an, ad, bn, bd, l, rr;
    an = an_i; ad = ad_i; bn = bn_i; bd = bd_i;
    r = '0;
    l = an * bd;
    rr = ad * bn;
    case (mode)
      ModeAdd: r = reduce_frac(an * bd + bn * ad, ad * bd);
      ModeSub: r = reduce_frac(an * bd - bn * ad, ad * bd);
      ModeMul: r = reduce_frac(an * bn, ad * bd);
      ModeDiv: r = reduce_frac(an * bd, ad * bn);
      ModeNeg: r = reduce_frac(-an, ad);
      ModeInc, ModeDec: begin
        if (ad == 0) begin
          r.den = 31'd1;
          r.err = 1'b1;
        end else begin
          r.num = 32'((mode == ModeInc) ? an + ad : an - ad);
          r.den = 31'(ad);
        end
      end
      ModeLt: r.cmp = l < rr;
      ModeLe: r.cmp = l <= rr;
      ModeGt: r.cmp = l > rr;
      ModeGe: r.cmp = l >= rr;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Send one beat, with an optional random gap first
  task automatic send_frac(logic [3:0] mode, logic [15:0] an, logic [14:0] ad,
                           logic [15:0] bn, logic [14:0] bd);
    if (!quiet && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tdata  <= {6'd0, bd, bn, ad, an, mode};
    s_axis_tvalid <= 1'b1;
    expected_q.push_back(predict_frac(mode, an, ad, bn, bd));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_num();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] rnd_den();
    case ($urandom_range(6))
      0: return 15'h7fff;
      1: return 15'd1;
      2: return 15'($urandom_range(1, 12));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  // Receiver: random stalls, check each beat against the oldest prediction
  always @(negedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (quiet) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(3) != 0);
  end

  always @(posedge clk_i) begin
    frac_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[64:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.num !== exp_r.num) begin
          $display("%0t: res_num exp %h got %h", $time, exp_r.num, got.num);
          n_errors++;
        end
        if (got.den !== exp_r.den) begin
          $display("%0t: res_den exp %h got %h", $time, exp_r.den, got.den);
          n_errors++;
        end
        if (got.cmp !== exp_r.cmp) begin
          $display("%0t: cmp_true exp %b got %b", $time, exp_r.cmp, got.cmp);
          n_errors++;
        end
        if (got.err !== exp_r.err) begin
          $display("%0t: div_error exp %b got %b", $time, exp_r.err, got.err);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Extremes of every field and each special case
  task automatic test_directed();
    for (int m = 0; m < 16; m++) send_frac(m[3:0], 16'h8000, 15'h7fff, 16'h7fff, 15'd1);
    send_frac(ModeDiv, 16'd3, 15'd4, 16'd0, 15'd5);       // divide by zero fraction
    send_frac(ModeAdd, 16'd1, 15'd0, 16'd1, 15'd2);       // zero input denominator
    send_frac(ModeInc, 16'd5, 15'd0, 16'd0, 15'd1);
    send_frac(ModeLt, 16'd2, 15'd0, 16'hffff, 15'd3);     // compare with zero denominator
    send_frac(ModeMul, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
    send_frac(ModeSub, 16'hffff, 15'd2, 16'hffff, 15'd2); // zero numerator result
    send_frac(ModeNeg, 16'h8000, 15'd1, 16'd0, 15'd1);
  endtask

  // Receiver held off while the sender keeps offering beats
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_frac(ModeInc, rnd_num(), rnd_den(), rnd_num(), rnd_den());
    join
  endtask

  task automatic test_random(int count);
    logic [3:0] m;
    for (int i = 0; i < count; i++) begin
      m = ($urandom_range(15) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
      send_frac(m, rnd_num(), ($urandom_range(60) == 0) ? 15'd0 : rnd_den(),
                ($urandom_range(20) == 0) ? 16'd0 : rnd_num(), rnd_den());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1000);
    quiet = 1'b1;
    test_random(200);
    end_stream();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
